// File: hw/rtl/eert_pkg.sv
// Shared types and constants for the echo edge range tracker.
// Used by eert_state, eert_dist and echo_edge_range_tracker; no dependencies.
`default_nettype none

package eert_pkg;

   // field widths
   localparam int TIMER_W = 16;
   localparam int DIST_W  = 14;
   localparam int CODE_W  = 3;
   localparam int PHASE_W = 3;

   // default timer counter width
   localparam int COUNT_WIDTH_DEF = 16;

   // cycle phases
   localparam logic [PHASE_W-1:0] PH_INIT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_TRIG    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_RISEN   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PROBLEM = 3'd4;

   // reading codes
   localparam logic [CODE_W-1:0] CODE_VALID    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_NONE     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_BAD_RISE = 3'd2;
   localparam logic [CODE_W-1:0] CODE_BAD_FALL = 3'd3;
   localparam logic [CODE_W-1:0] CODE_MISSED   = 3'd4;

   // distance = diff * 10 / 58 = diff * 5 / 29, saturating at DIST_MAX.
   // Any diff at or above DIFF_SAT saturates, so the multiply only sees
   // diff below 2^17, where diff * RECIP_MUL >> RECIP_SHIFT is exact.
   localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;
   localparam int DIFF_SAT    = 95028;
   localparam int DIFF_W      = 17;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 22;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 20'd723156;

   typedef struct packed {
      logic               mode;
      logic               echo_level;
      logic [TIMER_W-1:0] timer_count;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance_mm;
      logic [CODE_W-1:0]  reading_code;
      logic [PHASE_W-1:0] cycle_phase;
   } rsp_type;

   // one tracked event on its way to the distance stage
   typedef struct packed {
      logic               fall_ok;
      logic               sat;
      logic [DIFF_W-1:0]  diff;
      logic [CODE_W-1:0]  code;
      logic [PHASE_W-1:0] phase;
   } meas_type;

endpackage

`default_nettype wire

// File: hw/rtl/eert_state.sv
// Phase tracker: takes edge and tick requests, updates phase, code and rise count.
// Depends on eert_pkg; feeds one registered event record to eert_dist.
`default_nettype none

module eert_state #(
   parameter int COUNT_WIDTH = eert_pkg::COUNT_WIDTH_DEF
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  eert_pkg::req_type  req_data,
   input  wire                logic req_valid,
   output logic               req_stall,
   input  wire                logic meas_ready,
   output eert_pkg::meas_type meas,
   output logic               meas_valid
);

   localparam int EXT_W  = COUNT_WIDTH + eert_pkg::TIMER_W;
   localparam int WIDE_W = COUNT_WIDTH + eert_pkg::DIFF_W;

   logic [eert_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [eert_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [COUNT_WIDTH-1:0]       rise_ff, rise_in;
   eert_pkg::meas_type           meas_ff, meas_in;
   logic                         meas_valid_ff, meas_valid_in;

   logic                   accept;
   logic                   fall_ok;
   logic [EXT_W-1:0]       cnt_ext;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] diff;
   logic [WIDE_W-1:0]      diff_wide;

   // hold the request while the distance stage is full and blocked
   assign req_stall = meas_valid_ff && !meas_ready;
   assign accept    = req_valid && !req_stall;

   // timer count reduced to the counter width
   assign cnt_ext = {{COUNT_WIDTH{1'b0}}, req_data.timer_count};
   assign cnt     = cnt_ext[COUNT_WIDTH-1:0];

   // pulse width, wraps with the counter
   assign diff      = cnt - rise_ff;
   assign diff_wide = {{eert_pkg::DIFF_W{1'b0}}, diff};

   // next phase and code; an error only replaces a valid reading
   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      rise_in  = rise_ff;
      fall_ok  = 1'b0;
      if (req_data.mode) begin
         if (phase_ff != eert_pkg::PH_DONE && code_ff == eert_pkg::CODE_VALID) begin
            code_in = eert_pkg::CODE_MISSED;
         end
         phase_in = eert_pkg::PH_TRIG;
      end else if (req_data.echo_level) begin
         if (phase_ff == eert_pkg::PH_TRIG) begin
            phase_in = eert_pkg::PH_RISEN;
            rise_in  = cnt;
         end else begin
            phase_in = eert_pkg::PH_PROBLEM;
            if (code_ff == eert_pkg::CODE_VALID) begin
               code_in = eert_pkg::CODE_BAD_RISE;
            end
         end
      end else begin
         if (phase_ff == eert_pkg::PH_RISEN) begin
            phase_in = eert_pkg::PH_DONE;
            code_in  = eert_pkg::CODE_VALID;
            fall_ok  = 1'b1;
         end else begin
            phase_in = eert_pkg::PH_PROBLEM;
            if (code_ff == eert_pkg::CODE_VALID) begin
               code_in = eert_pkg::CODE_BAD_FALL;
            end
         end
      end
   end

   // event record for the distance stage
   always_comb begin
      meas_in.fall_ok = fall_ok;
      meas_in.sat     = diff_wide >= WIDE_W'(eert_pkg::DIFF_SAT);
      meas_in.diff    = diff_wide[eert_pkg::DIFF_W-1:0];
      meas_in.code    = code_in;
      meas_in.phase   = phase_in;
   end

   always_comb begin
      if (accept) begin
         meas_valid_in = 1'b1;
      end else if (meas_ready) begin
         meas_valid_in = 1'b0;
      end else begin
         meas_valid_in = meas_valid_ff;
      end
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= eert_pkg::PH_INIT;
         code_ff       <= eert_pkg::CODE_NONE;
         rise_ff       <= '0;
         meas_valid_ff <= 1'b0;
      end else begin
         meas_valid_ff <= meas_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            code_ff  <= code_in;
            rise_ff  <= rise_in;
         end
      end
   end

   // event payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         meas_ff <= meas_in;
      end
   end

   assign meas       = meas_ff;
   assign meas_valid = meas_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/eert_dist.sv
// Distance stage: reciprocal multiply for the pulse width and the result register.
// Depends on eert_pkg; takes event records from eert_state.
`default_nettype none

module eert_dist (
   input  wire                logic clock,
   input  wire                logic reset,
   input  eert_pkg::meas_type meas,
   input  wire                logic meas_valid,
   output logic               meas_ready,
   output eert_pkg::rsp_type  rsp_data,
   output logic               rsp_valid,
   input  wire                logic rsp_stall
);

   localparam int PROD_W = eert_pkg::DIFF_W + eert_pkg::RECIP_W;

   logic [eert_pkg::DIST_W-1:0] dist_ff, dist_in;
   eert_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        take;
   logic [PROD_W-1:0]           prod;
   logic [eert_pkg::DIST_W-1:0] new_dist;

   // result register frees when empty or when its request leaves
   assign meas_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = meas_valid && meas_ready;

   // diff * 5 / 29 via reciprocal, exact below the saturation point
   assign prod = {{eert_pkg::RECIP_W{1'b0}}, meas.diff}
               * {{eert_pkg::DIFF_W{1'b0}}, eert_pkg::RECIP_MUL};
   assign new_dist = meas.sat ? eert_pkg::DIST_MAX
                              : prod[eert_pkg::RECIP_SHIFT +: eert_pkg::DIST_W];

   // last valid distance, replaced only by a good fall
   assign dist_in = (take && meas.fall_ok) ? new_dist : dist_ff;

   always_comb begin
      rsp_in.distance_mm  = (meas.code == eert_pkg::CODE_VALID) ? dist_in : '0;
      rsp_in.reading_code = meas.code;
      rsp_in.cycle_phase  = meas.phase;
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dist_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dist_ff      <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/echo_edge_range_tracker.sv
// Echo edge range tracker, top level: phase tracker followed by distance stage.
// Pipeline: an accepted request is registered in the event register, then in the response register.
// Throughput: one request per cycle while req_stall is low; the tracker state updates on
// acceptance and the divide by 58 is one reciprocal multiply in the second stage.
// Reset: synchronous, active high; phase init, code none yet, both stages empty.
// Depends on eert_pkg, eert_state and eert_dist.
`default_nettype none

module echo_edge_range_tracker #(
   parameter int COUNT_WIDTH = eert_pkg::COUNT_WIDTH_DEF
) (
   input  wire               logic clock,
   input  wire               logic reset,
   input  eert_pkg::req_type req_data,
   input  wire               logic req_valid,
   output logic              req_stall,
   output eert_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  wire               logic rsp_stall
);

   eert_pkg::meas_type meas;
   logic               meas_valid;
   logic               meas_ready;

   // event tracking
   eert_state #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .meas_ready (meas_ready),
      .meas       (meas),
      .meas_valid (meas_valid)
   );

   // distance and response register
   eert_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .meas       (meas),
      .meas_valid (meas_valid),
      .meas_ready (meas_ready),
      .rsp_data   (rsp_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall)
   );

   // an accepted request always lands in the event register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> meas_valid)
      else $error("accepted request did not reach the event register");

   // no distance is shown without a valid reading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.reading_code != eert_pkg::CODE_VALID)
         |-> (rsp_data.distance_mm == '0))
      else $error("distance shown with an error or empty reading");

   // a problem phase can never leave a valid reading in place
   assert property (@(posedge clock) disable iff (reset)
      (meas_valid && meas.phase == eert_pkg::PH_PROBLEM)
         |-> (meas.code != eert_pkg::CODE_VALID))
      else $error("problem phase with valid reading code");

   // a good fall, the only event that loads a fresh or saturating distance, carries a valid code and the done phase
   assert property (@(posedge clock) disable iff (reset)
      (meas_valid && meas.fall_ok)
         |-> (meas.code == eert_pkg::CODE_VALID && meas.phase == eert_pkg::PH_DONE))
      else $error("good fall without valid code and done phase");

endmodule

`default_nettype wire
